### rtl/core/nwa_pkg.sv
// nwa_pkg: shared constants, codes and types of the NFA word acceptance unit.
// No dependencies; every other file of the block but nwa_out_if imports it.
`default_nettype none

package nwa_pkg;

  // defaults for the top-level parameters
  localparam int NumStatesDef  = 16;
  localparam int SymbolBitsDef = 8;

  // depth of the queue between front and back
  localparam int QueueDepth = 4;

  // fixed field widths of the channels and registers
  localparam int OpW         = 2;
  localparam int StateFieldW = 4;
  localparam int SymbolW     = 8;
  localparam int StartW      = 4;
  localparam int MaskW       = 16;

  // configuration port
  localparam int ApbAddrW = 3;
  localparam int ApbDataW = 32;

  typedef enum logic [OpW-1:0] {
    OP_ADD    = 2'd0,
    OP_SYMBOL = 2'd1,
    OP_QUERY  = 2'd2
  } op_e;

  typedef enum logic {
    REG_START_STATE = 1'b0,
    REG_FINAL_MASK  = 1'b1
  } reg_idx_e;

  // classified item held in the queue
  typedef struct packed {
    op_e                    op;
    logic [StateFieldW-1:0] from_state;
    logic [StateFieldW-1:0] to_state;
    logic [SymbolW-1:0]     symbol;
    logic                   last_symbol;
  } item_t;

  // table access issued by the back end
  typedef struct packed {
    logic                   rd_en;
    logic                   wr_en;
    logic [StateFieldW-1:0] from_state;
    logic [StateFieldW-1:0] to_state;
    logic [SymbolW-1:0]     symbol;
  } tbl_req_t;

endpackage

`default_nettype wire

### rtl/core/nwa_in_if.sv
// nwa_in_if: input channel of the NFA word acceptance unit (valid/ready + item).
// Depends on nwa_pkg for the field widths.
`default_nettype none

interface nwa_in_if;
  import nwa_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [OpW-1:0]         op;
  logic [StateFieldW-1:0] from_state;
  logic [StateFieldW-1:0] to_state;
  logic [SymbolW-1:0]     symbol;
  logic                   last_symbol;

  modport source (
    output valid, op, from_state, to_state, symbol, last_symbol,
    input  ready
  );

  modport sink (
    input  valid, op, from_state, to_state, symbol, last_symbol,
    output ready
  );

endinterface

`default_nettype wire

### rtl/core/nwa_out_if.sv
// nwa_out_if: result channel of the NFA word acceptance unit (valid/ready + accepted).
// No dependencies.
`default_nettype none

interface nwa_out_if;

  logic valid;
  logic ready;
  logic accepted;

  modport source (
    output valid, accepted,
    input  ready
  );

  modport sink (
    input  valid, accepted,
    output ready
  );

endinterface

`default_nettype wire

### rtl/core/nwa_front.sv
// nwa_front: accepts input beats, drops ignored ones, pushes the rest to the queue.
// Depends on nwa_pkg and nwa_in_if.
`default_nettype none

module nwa_front #(
  parameter int NUM_STATES = 16
) (
  nwa_in_if.sink             in_chan_i,
  input  logic               clr_busy_i,
  input  logic               q_full_i,
  output logic               push_o,
  output nwa_pkg::item_t     push_item_o
);
  import nwa_pkg::*;

  logic accept;
  logic keep;
  logic from_ok;
  logic to_ok;

  assign in_chan_i.ready = !q_full_i && !clr_busy_i;
  assign accept          = in_chan_i.valid && in_chan_i.ready;

  // a state index at or above NUM_STATES names no state
  assign from_ok = 32'(in_chan_i.from_state) < NUM_STATES;
  assign to_ok   = 32'(in_chan_i.to_state) < NUM_STATES;

  always_comb begin
    case (in_chan_i.op)
      OP_ADD:    keep = from_ok && to_ok;
      OP_SYMBOL: keep = 1'b1;
      OP_QUERY:  keep = 1'b1;
      default:   keep = 1'b0;
    endcase
  end

  assign push_o                  = accept && keep;
  assign push_item_o.op          = op_e'(in_chan_i.op);
  assign push_item_o.from_state  = in_chan_i.from_state;
  assign push_item_o.to_state    = in_chan_i.to_state;
  assign push_item_o.symbol      = in_chan_i.symbol;
  assign push_item_o.last_symbol = in_chan_i.last_symbol;

endmodule

`default_nettype wire

### rtl/core/nwa_queue.sv
// nwa_queue: small flop-based FIFO of classified items between front and back.
// Depends on nwa_pkg.
`default_nettype none

module nwa_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  nwa_pkg::item_t push_item_i,
  output logic           full_o,
  output logic           head_valid_o,
  output nwa_pkg::item_t head_item_o,
  input  logic           pop_i
);
  import nwa_pkg::*;

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  item_t            entries_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push;
  logic             do_pop;

  assign full_o       = count_q == CntW'(DEPTH);
  assign head_valid_o = count_q != '0;
  assign head_item_o  = entries_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

`default_nettype wire

### rtl/core/nwa_table.sv
// nwa_table: transition table, one memory bank per source state, with clearing pass.
// Depends on nwa_pkg.
`default_nettype none

module nwa_table #(
  parameter int NUM_STATES  = 16,
  parameter int SYMBOL_BITS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  nwa_pkg::tbl_req_t     req_i,
  output logic                  clr_busy_o,
  output logic [NUM_STATES-1:0] rows_o [NUM_STATES]
);
  import nwa_pkg::*;

  localparam int Rows   = 1 << SYMBOL_BITS;
  localparam int StateW = $clog2(NUM_STATES);

  logic [SYMBOL_BITS-1:0] clr_addr_q;
  logic                   clr_busy_q;
  logic [SYMBOL_BITS-1:0] addr;
  logic [StateW-1:0]      wr_bit;

  assign addr       = req_i.symbol[SYMBOL_BITS-1:0];
  assign wr_bit     = StateW'(req_i.to_state);
  assign clr_busy_o = clr_busy_q;

  // sweep every row of all banks once after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
      clr_busy_q <= 1'b1;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + 1'b1;
      if (clr_addr_q == '1) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  for (genvar b = 0; b < NUM_STATES; b++) begin : g_bank
    logic [NUM_STATES-1:0] mem [Rows];
    logic                  bank_wr;

    assign bank_wr = req_i.wr_en && (32'(req_i.from_state) == b);

    always_ff @(posedge clk_i) begin
      if (clr_busy_q) begin
        mem[clr_addr_q] <= '0;
      end else if (bank_wr) begin
        mem[addr][wr_bit] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rows_o[b] <= mem[addr];
      end
    end
  end

endmodule

`default_nettype wire

### rtl/core/nwa_back.sv
// nwa_back: executes queued items: table access, active-set update, result register.
// Depends on nwa_pkg and nwa_out_if.
`default_nettype none

module nwa_back #(
  parameter int NUM_STATES  = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        head_valid_i,
  input  nwa_pkg::item_t              head_item_i,
  output logic                        pop_o,
  input  logic                        clr_busy_i,
  output nwa_pkg::tbl_req_t           tbl_req_o,
  input  logic [NUM_STATES-1:0]       rows_i [NUM_STATES],
  input  logic [nwa_pkg::StartW-1:0]  start_state_i,
  input  logic [nwa_pkg::MaskW-1:0]   final_mask_i,
  nwa_out_if.source                   out_chan_o
);
  import nwa_pkg::*;

  localparam int MaskExtW = (NUM_STATES > MaskW) ? NUM_STATES : MaskW;

  item_t                 ex_item_q;
  logic                  ex_valid_q;
  logic [NUM_STATES-1:0] active_q, active_d;
  logic                  in_word_q;
  logic                  out_valid_q;
  logic                  out_acc_q;

  logic [MaskExtW-1:0]   mask_ext;
  logic [NUM_STATES-1:0] mask_ns;
  logic [NUM_STATES-1:0] start_bit;
  logic [NUM_STATES-1:0] cur;
  logic                  is_sym;
  logic                  is_qry;
  logic                  has_res;
  logic                  res_val;
  logic                  ex_adv;
  logic                  retire;
  logic                  res_fire;

  assign mask_ext  = MaskExtW'(final_mask_i);
  assign mask_ns   = mask_ext[NUM_STATES-1:0];
  assign start_bit = (32'(start_state_i) < NUM_STATES)
                   ? ({{(NUM_STATES-1){1'b0}}, 1'b1} << start_state_i) : '0;

  assign is_sym  = ex_item_q.op == OP_SYMBOL;
  assign is_qry  = ex_item_q.op == OP_QUERY;
  assign has_res = (is_sym && ex_item_q.last_symbol) || is_qry;

  // execute stage moves unless it holds a result the output cannot take
  assign ex_adv   = !ex_valid_q || !has_res || !out_valid_q || out_chan_o.ready;
  assign retire   = ex_valid_q && ex_adv;
  assign res_fire = retire && has_res;
  assign pop_o    = head_valid_i && ex_adv && !clr_busy_i;

  // table read for symbols, bit write for transitions, both at the pop edge
  assign tbl_req_o.rd_en      = pop_o && (head_item_i.op == OP_SYMBOL);
  assign tbl_req_o.wr_en      = pop_o && (head_item_i.op == OP_ADD);
  assign tbl_req_o.from_state = head_item_i.from_state;
  assign tbl_req_o.to_state   = head_item_i.to_state;
  assign tbl_req_o.symbol     = head_item_i.symbol;

  // OR of the rows of every active state
  assign cur = in_word_q ? active_q : start_bit;
  always_comb begin
    active_d = '0;
    for (int s = 0; s < NUM_STATES; s++) begin
      if (cur[s]) begin
        active_d = active_d | rows_i[s];
      end
    end
  end

  assign res_val = is_sym ? |(active_d & mask_ns) : |(start_bit & mask_ns);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ex_valid_q  <= 1'b0;
      in_word_q   <= 1'b0;
      active_q    <= {{(NUM_STATES-1){1'b0}}, 1'b1};
      out_valid_q <= 1'b0;
    end else begin
      if (ex_adv) begin
        ex_valid_q <= pop_o;
      end
      if (retire && is_sym) begin
        active_q  <= active_d;
        in_word_q <= !ex_item_q.last_symbol;
      end
      if (res_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_chan_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ex_adv && pop_o) begin
      ex_item_q <= head_item_i;
    end
    if (res_fire) begin
      out_acc_q <= res_val;
    end
  end

  assign out_chan_o.valid    = out_valid_q;
  assign out_chan_o.accepted = out_acc_q;

  // a new result never overwrites a beat still waiting at the output
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_fire |-> (!out_valid_q || out_chan_o.ready))
    else $error("result overwrote a pending output beat");

  // no item leaves the queue while the table is being cleared
  a_no_pop_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_i |-> !pop_o)
    else $error("pop during table clearing pass");

  // the last symbol of a word closes the word
  a_word_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (retire && is_sym && ex_item_q.last_symbol) |=> !in_word_q)
    else $error("word still open after last symbol");

  // a retired result shows up as an output beat in the next cycle
  a_result_visible: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_fire |=> out_chan_o.valid)
    else $error("retired result not presented");

endmodule

`default_nettype wire

### rtl/core/nfa_word_acceptance_unit.sv
// nfa_word_acceptance_unit: top level of the NFA word acceptance unit.
// Depends on nwa_pkg, nwa_in_if, nwa_out_if, nwa_front, nwa_queue, nwa_table, nwa_back.
//
// Usage:
//   in_chan_i  : valid/ready input beats. op 0 adds a transition (from_state,
//                symbol -> to_state), op 1 feeds one word symbol (last_symbol
//                ends the word), op 2 asks whether the empty word is accepted.
//                op 3 and transitions naming a state >= NUM_STATES are dropped.
//   out_chan_o : one beat with accepted per finished word and per empty-word
//                query, in input order.
//   APB port   : start_state at 0x0, final_mask at 0x4; write only while idle.
// Throughput: one input beat per cycle unless out_chan_o stalls or the table is being
//   cleared; the execute stage reads all state banks of the transition table in
//   parallel and ORs the active rows combinationally, so consecutive symbols of a
//   word issue back to back.
// Path: an accepted input beat is written into the queue, popped with its table read
//   into the execute stage, then executed into the output register.
// Reset: the table is swept clean row by row with in_chan_i.ready low; APB writes
//   are taken during the sweep.
// Stall: while out_chan_o is stalled the result is held in the output
//   register; the queue (QueueDepth entries) absorbs input until it fills,
//   then in_chan_i.ready drops.
`default_nettype none

module nfa_word_acceptance_unit #(
  parameter int NUM_STATES  = nwa_pkg::NumStatesDef,
  parameter int SYMBOL_BITS = nwa_pkg::SymbolBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  nwa_in_if.sink                        in_chan_i,
  nwa_out_if.source                     out_chan_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [nwa_pkg::ApbAddrW-1:0]  paddr,
  input  logic [nwa_pkg::ApbDataW-1:0]  pwdata,
  output logic [nwa_pkg::ApbDataW-1:0]  prdata,
  output logic                          pready
);
  import nwa_pkg::*;

  // configuration registers
  logic [StartW-1:0] start_state_q;
  logic [MaskW-1:0]  final_mask_q;
  logic              cfg_wr;
  reg_idx_e          reg_idx;

  // front/queue/back wiring
  logic                  push;
  item_t                 push_item;
  logic                  q_full;
  logic                  head_valid;
  item_t                 head_item;
  logic                  pop;
  logic                  clr_busy;
  tbl_req_t              tbl_req;
  logic [NUM_STATES-1:0] rows [NUM_STATES];

  // ---------------- APB register file ----------------
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_state_q <= '0;
      final_mask_q  <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_START_STATE: start_state_q <= pwdata[StartW-1:0];
        REG_FINAL_MASK:  final_mask_q  <= pwdata[MaskW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_START_STATE: prdata = ApbDataW'(start_state_q);
      REG_FINAL_MASK:  prdata = ApbDataW'(final_mask_q);
      default:         prdata = '0;
    endcase
  end

  // ---------------- front: accept and classify ----------------
  nwa_front #(
    .NUM_STATES (NUM_STATES)
  ) u_front (
    .in_chan_i   (in_chan_i),
    .clr_busy_i  (clr_busy),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_item_o (push_item)
  );

  // ---------------- decoupling queue ----------------
  nwa_queue #(
    .DEPTH (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_item_i  (push_item),
    .full_o       (q_full),
    .head_valid_o (head_valid),
    .head_item_o  (head_item),
    .pop_i        (pop)
  );

  // ---------------- banked transition table ----------------
  nwa_table #(
    .NUM_STATES  (NUM_STATES),
    .SYMBOL_BITS (SYMBOL_BITS)
  ) u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (tbl_req),
    .clr_busy_o (clr_busy),
    .rows_o     (rows)
  );

  // ---------------- back: execute and deliver ----------------
  nwa_back #(
    .NUM_STATES (NUM_STATES)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_valid_i  (head_valid),
    .head_item_i   (head_item),
    .pop_o         (pop),
    .clr_busy_i    (clr_busy),
    .tbl_req_o     (tbl_req),
    .rows_i        (rows),
    .start_state_i (start_state_q),
    .final_mask_i  (final_mask_q),
    .out_chan_o    (out_chan_o)
  );

endmodule

`default_nettype wire

### tb/sv/nwa_acceptance_checker.sv
`timescale 1ns / 100ps
// nwa_acceptance_checker: watches the input, result and APB channels of the NFA word
// acceptance unit, predicts the accept beats and compares them in order.
// Depends on nwa_pkg, nwa_in_if and nwa_out_if.

module nwa_acceptance_checker #(
  parameter int NUM_STATES  = nwa_pkg::NumStatesDef,
  parameter int SYMBOL_BITS = nwa_pkg::SymbolBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  nwa_in_if                            in_mon,
  nwa_out_if                           out_mon,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic                         pready,
  input  logic [nwa_pkg::ApbAddrW-1:0] paddr,
  input  logic [nwa_pkg::ApbDataW-1:0] pwdata,
  output int                           fail_count_o,
  output int                           pending_o,
  output int                           checked_o
);
  import nwa_pkg::*;

  localparam int          TableRows  = NUM_STATES << SYMBOL_BITS;
  localparam int unsigned SymMask    = (1 << SYMBOL_BITS) - 1;
  localparam int          MaxReports = 40;

  typedef logic [NUM_STATES-1:0] state_set_t;

  state_set_t           nfa_rows [TableRows];
  state_set_t           live_set;
  logic                 word_open;
  logic [StartW-1:0]    cfg_start;
  logic [MaskW-1:0]     cfg_final;
  bit                   accept_q [$];
  int                   row;

  function automatic state_set_t state_onehot(int unsigned s);
    state_set_t v;
    v = '0;
    if (s < NUM_STATES) v[s] = 1'b1;
    return v;
  endfunction

  // final bits at or above NUM_STATES do not count
  function automatic bit any_final(state_set_t set);
    state_set_t fm;
    int         b;
    fm = '0;
    for (b = 0; b < NUM_STATES && b < MaskW; b++) fm[b] = cfg_final[b];
    return |(set & fm);
  endfunction

  task automatic report_mismatch(string what);
    fail_count_o++;
    if (fail_count_o <= MaxReports) $display("%0t: MISMATCH %s", $time, what);
  endtask

  task automatic apply_item(logic [OpW-1:0] op, logic [StateFieldW-1:0] from,
                            logic [StateFieldW-1:0] to, logic [SymbolW-1:0] sym,
                            logic last);
    int unsigned code;
    state_set_t  cur;
    state_set_t  nxt;
    int          s;
    code = int'(sym) & SymMask;
    case (op)
      OP_ADD: begin
        if (from < NUM_STATES && to < NUM_STATES)
          nfa_rows[(int'(from) << SYMBOL_BITS) | code] |= state_onehot(to);
      end
      OP_SYMBOL: begin
        // a new word starts from the start state as it is now
        cur = word_open ? live_set : state_onehot(cfg_start);
        nxt = '0;
        for (s = 0; s < NUM_STATES; s++)
          if (cur[s]) nxt |= nfa_rows[(s << SYMBOL_BITS) | code];
        live_set = nxt;
        if (last) begin
          word_open = 1'b0;
          accept_q.push_back(any_final(nxt));
        end else begin
          word_open = 1'b1;
        end
      end
      OP_QUERY: accept_q.push_back(any_final(state_onehot(cfg_start)));
      default: ;
    endcase
  endtask

  task automatic check_accept(logic got);
    bit want;
    if (accept_q.size() == 0) begin
      report_mismatch($sformatf("result beat accepted=%b with nothing expected", got));
    end else begin
      want = accept_q.pop_front();
      checked_o++;
      if (got !== want)
        report_mismatch($sformatf("accepted=%b expected %b (result %0d)", got, want,
                                  checked_o));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (row = 0; row < TableRows; row++) nfa_rows[row] = '0;
      cfg_start = '0;
      cfg_final = '0;
      live_set  = state_onehot(0);
      word_open = 1'b0;
      accept_q.delete();
      pending_o = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00) begin
        case (reg_idx_e'(paddr[2]))
          REG_START_STATE: cfg_start = pwdata[StartW-1:0];
          REG_FINAL_MASK:  cfg_final = pwdata[MaskW-1:0];
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) check_accept(out_mon.accepted);
      if (in_mon.valid && in_mon.ready)
        apply_item(in_mon.op, in_mon.from_state, in_mon.to_state, in_mon.symbol,
                   in_mon.last_symbol);
      pending_o = accept_q.size();
    end
  end

endmodule

### tb/sv/nfa_word_acceptance_unit_tb.sv
`timescale 1ns / 100ps
// nfa_word_acceptance_unit_tb: stimulus and verdict for the NFA word acceptance unit.
// Depends on nwa_pkg, nwa_in_if, nwa_out_if, the block and nwa_acceptance_checker.

module nfa_word_acceptance_unit_tb;
  import nwa_pkg::*;

  localparam int             TotalItems     = 1550;
  localparam int             LatencyGuard   = 8;    // margin waited after the last expected result
  localparam int             LongHoldCycles = 300;  // receiver hold-off, fills the queue
  localparam int             CycleLimit     = 600000;
  localparam logic [OpW-1:0] OpUnused       = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always #2 clk = ~clk;

  nwa_in_if  in_chan ();
  nwa_out_if out_chan ();

  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  int chk_fails;
  int chk_pending;
  int chk_checked;

  // stimulus bookkeeping
  int         items_sent = 0;
  int         long_holds = 0;
  int         cycle_count = 0;
  bit         tx_steady = 1'b0;   // sender offers back to back
  bit         rx_steady = 1'b0;   // receiver takes no random stalls
  bit         long_hold_req = 1'b0;
  logic [7:0] alpha_base = '0;    // current phase alphabet: alpha_base + 0..alpha_n-1
  int         alpha_n = 1;
  logic [3:0] cur_start = '0;
  logic [3:0] chain_state = '0;

  nfa_word_acceptance_unit dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_chan_i  (in_chan),
    .out_chan_o (out_chan),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  nwa_acceptance_checker acceptance_chk (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_mon       (in_chan),
    .out_mon      (out_chan),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .fail_count_o (chk_fails),
    .pending_o    (chk_pending),
    .checked_o    (chk_checked)
  );

  // watchdog over the whole run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               chk_pending);
      $display("Regression FAIL");
      $finish;
    end
  end

  // idle length: mostly short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // symbol of the current alphabet, rarely anything at all
  function automatic logic [7:0] pick_symbol();
    if ($urandom_range(0, 99) < 5) return 8'($urandom);
    return alpha_base + 8'($urandom_range(0, alpha_n - 1));
  endfunction

  // Receiver: random stalls; a long hold-off when the stimulus asks for one.
  initial begin
    int hold;
    out_chan.ready = 1'b0;
    hold = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        hold = LongHoldCycles;
        long_hold_req = 1'b0;
        long_holds++;
      end
      if (hold > 0) begin
        out_chan.ready <= 1'b0;
        hold--;
      end else if (rx_steady || $urandom_range(0, 99) < 75) begin
        out_chan.ready <= 1'b1;
      end else begin
        out_chan.ready <= 1'b0;
        hold = idle_len() - 1;
      end
    end
  end

  // One input beat; valid stays high across back-to-back beats.
  task automatic send_beat(logic [OpW-1:0] op, logic [3:0] from, logic [3:0] to,
                           logic [7:0] sym, logic last);
    int gap;
    gap = (tx_steady || $urandom_range(0, 99) < 70) ? 0 : idle_len();
    @(negedge clk);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_chan.valid       <= 1'b1;
    in_chan.op          <= op;
    in_chan.from_state  <= from;
    in_chan.to_state    <= to;
    in_chan.symbol      <= sym;
    in_chan.last_symbol <= last;
    do @(posedge clk); while (!in_chan.ready);
    items_sent++;
  endtask

  task automatic send_add(logic [3:0] from, logic [3:0] to, logic [7:0] sym);
    send_beat(OP_ADD, from, to, sym, 1'($urandom));
  endtask

  task automatic send_sym(logic [7:0] sym, logic last);
    send_beat(OP_SYMBOL, 4'($urandom), 4'($urandom), sym, last);
  endtask

  task automatic send_query();
    send_beat(OP_QUERY, 4'($urandom), 4'($urandom), 8'($urandom), 1'($urandom));
  endtask

  // Stop offering until every expected beat is out, then let in-flight symbols settle.
  task automatic drain();
    @(negedge clk);
    in_chan.valid <= 1'b0;
    while (chk_pending != 0) @(negedge clk);
    repeat (LatencyGuard) @(negedge clk);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [ApbDataW-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // New register setting once the block is idle; unused upper data bits get junk.
  task automatic retune(logic [3:0] start, logic [15:0] mask);
    drain();
    write_reg(REG_START_STATE, ($urandom & 32'hFFFF_FFF0) | start);
    write_reg(REG_FINAL_MASK, ($urandom & 32'hFFFF_0000) | mask);
    cur_start   = start;
    chain_state = start;
  endtask

  // One random phase: build part of an automaton on a small alphabet, then run words
  // through it with queries, unused ops and late transitions mixed in.
  task automatic run_random_phase(int phase_no);
    int         n_adds;
    int         n_words;
    int         wlen;
    int         k;
    int         r;
    logic [3:0] from;
    logic [3:0] to;
    alpha_base = 8'($urandom);
    alpha_n    = $urandom_range(1, 4);
    tx_steady  = ($urandom_range(0, 2) == 0);
    rx_steady  = ($urandom_range(0, 2) == 0);
    if (phase_no % 6 == 1) begin
      // receiver stalls while we keep offering: queue fills, input ready drops
      tx_steady     = 1'b1;
      long_hold_req = 1'b1;
      repeat (8) send_query();
    end
    // chains out of the start state keep the active set alive for a while
    n_adds = alpha_n * $urandom_range(4, 12);
    repeat (n_adds) begin
      from = ($urandom_range(0, 2) != 0) ? chain_state : 4'($urandom);
      to   = 4'($urandom);
      send_add(from, to, pick_symbol());
      chain_state = ($urandom_range(0, 3) == 0) ? cur_start : to;
    end
    n_words = $urandom_range(4, 10);
    repeat (n_words) begin
      r = $urandom_range(0, 99);
      wlen = (r < 80) ? $urandom_range(1, 4) : (r < 95) ? $urandom_range(5, 10)
                                                         : $urandom_range(11, 24);
      for (k = 0; k < wlen; k++) begin
        r = $urandom_range(0, 99);
        if (r < 5) send_query();
        else if (r < 8)
          send_beat(OpUnused, 4'($urandom), 4'($urandom), 8'($urandom), 1'($urandom));
        else if (r < 12) send_add(4'($urandom), 4'($urandom), pick_symbol());
        send_sym(pick_symbol(), k == wlen - 1);
      end
    end
    // sometimes leave a word open across the next register write
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) send_sym(pick_symbol(), 1'b0);
  endtask

  initial begin
    int         phase_no;
    int         r;
    logic [3:0] st;
    logic [15:0] fm;
    in_chan.valid       = 1'b0;
    in_chan.op          = OP_ADD;
    in_chan.from_state  = '0;
    in_chan.to_state    = '0;
    in_chan.symbol      = '0;
    in_chan.last_symbol = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    phase_no = 0;

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // --- directed part ---
    tx_steady = 1'b1;
    rx_steady = 1'b1;
    retune(4'd0, 16'h0000);
    send_query();                      // no final state at all
    send_add(4'd0, 4'd1, 8'h00);       // extremes of states and symbols
    send_add(4'd1, 4'd15, 8'hFF);
    send_add(4'd15, 4'd0, 8'hFF);
    send_add(4'd0, 4'd15, 8'hFF);
    send_add(4'd15, 4'd15, 8'h00);
    send_sym(8'h00, 1'b0);
    send_sym(8'hFF, 1'b1);
    send_beat(OpUnused, 4'd15, 4'd15, 8'hFF, 1'b1);  // unused op, dropped
    retune(4'd0, 16'h0001);
    send_query();                      // start state is final
    send_sym(8'hFF, 1'b0);
    send_sym(8'hFF, 1'b1);             // back to state 0: accepted
    send_sym(8'h00, 1'b1);             // one-symbol word
    send_sym(8'h55, 1'b0);             // no transition: active set dies
    send_sym(8'h00, 1'b1);
    send_sym(8'h00, 1'b0);
    send_add(4'd1, 4'd2, 8'h10);       // transition lands mid-word
    send_query();                      // query inside a word
    send_sym(8'h10, 1'b1);
    retune(4'd15, 16'hFFFF);
    send_query();
    send_sym(8'hFF, 1'b1);
    send_sym(8'h00, 1'b0);             // word left open at state 15
    retune(4'd0, 16'h8000);            // start change must wait for the next word
    send_sym(8'hFF, 1'b1);
    send_query();
    send_sym(8'h00, 1'b1);

    // --- random part ---
    while (items_sent < TotalItems) begin
      r  = $urandom_range(0, 9);
      st = (r == 0) ? 4'd0 : (r == 1) ? 4'd15 : 4'($urandom);
      r  = $urandom_range(0, 9);
      fm = (r == 0) ? 16'h0000 : (r == 1) ? 16'hFFFF :
           (r < 4) ? (16'h0001 << $urandom_range(0, 15)) : 16'($urandom);
      retune(st, fm);
      run_random_phase(phase_no);
      phase_no++;
    end

    drain();
    repeat (4 * LatencyGuard) @(posedge clk);

    $display("%0d input beats in %0d random phases plus directed cases, %0d results checked",
             items_sent, phase_no, chk_checked);
    $display("%0d long receiver hold-offs, %0d mismatches", long_holds, chk_fails);
    if (chk_fails == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/nwa_pkg.sv
rtl/core/nwa_in_if.sv
rtl/core/nwa_out_if.sv
rtl/core/nwa_front.sv
rtl/core/nwa_queue.sv
rtl/core/nwa_table.sv
rtl/core/nwa_back.sv
rtl/core/nfa_word_acceptance_unit.sv
tb/sv/nwa_acceptance_checker.sv
tb/sv/nfa_word_acceptance_unit_tb.sv
